### rtl/knn_pkg.sv
package knn_pkg;

   localparam int MaxNodes = 256;
   localparam int KMax = 16;
   localparam int IdxW = $clog2(MaxNodes);
   localparam int CntW = $clog2(MaxNodes + 1);
   localparam int KW = $clog2(KMax + 1);
   localparam int SlotW = $clog2(KMax);
   localparam int DistW = 35;

   localparam logic [2:0] ST_EDGE = 3'd0;
   localparam logic [2:0] ST_LOADED = 3'd1;
   localparam logic [2:0] ST_PRESENT = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [0:0] REG_NEIGHBORS_K = 1'd0;

   typedef struct packed {
      logic cmd;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] node_index;
      logic [7:0] neighbor_index;
      logic last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;     // latch the request and clear the best list
      logic rd_issue;    // read stored point at scan index
      logic scan_clr;    // restart scan index at zero
      logic dist_en;     // compute distance of point read last cycle
      logic ins_en;      // insert registered distance into best list
      logic write_pt;    // store request point at node_count
      logic emit_edge;   // advance edge slot counter as an edge is taken
      logic [2:0] status;
      logic out_clr;     // restart edge slot counter
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic cmd;
      logic full;
      logic empty;
      logic scan_done;   // scan index reached node_count
      logic match;       // a scanned point had zero distance
      logic last_edge;   // current edge slot is the final one
   } sts_type;

endpackage

### rtl/knn_roadmap_node_insert_top.sv
// Stores up to 256 3-D points and connects each inserted point to its k nearest
// stored points (register neighbors_k at address 0, clamped to 1..16). An
// insert scans the store up to twice through one memory read port, first for a
// duplicate and then, if none is found and the store is not full, for the
// k-best list, and then emits one edge per cycle while rsp_ready is high.
// Results leave in ascending squared distance, ties to the lower index; last
// marks the final result of each transaction.
module knn_roadmap_node_insert_top
   import knn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctl_type ctl;
   sts_type sts;
   logic [4:0] nk_ff;
   logic [KW-1:0] kk;

   always_ff @(posedge clock) begin
      if (reset) begin
         nk_ff <= 5'd4;
      end else if (psel && penable && pwrite && paddr[2] == REG_NEIGHBORS_K) begin
         nk_ff <= pwdata[4:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_NEIGHBORS_K) ? {27'd0, nk_ff} : '0;

   always_comb begin
      if (nk_ff == '0) begin
         kk = KW'(1);
      end else if (32'(nk_ff) > KMax) begin
         kk = KW'(KMax);
      end else begin
         kk = KW'(nk_ff);
      end
   end

   knn_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .ctl(ctl), .sts(sts)
   );

   knn_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_in(req_data), .kk_in(kk), .rsp_data(rsp_data)
   );

endmodule

### rtl/knn_datapath.sv
module knn_datapath
   import knn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ctl_type        ctl,
   output sts_type        sts,
   input  req_type        req_in,
   input  logic [KW-1:0]  kk_in,
   output rsp_type        rsp_data
);

   logic [15:0] mem_x [MaxNodes];
   logic [15:0] mem_y [MaxNodes];
   logic [15:0] mem_z [MaxNodes];
   logic [15:0] rd_x_ff, rd_y_ff, rd_z_ff;

   req_type req_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [IdxW-1:0] rd_idx_ff;      // index of point held in rd_*_ff
   logic [IdxW-1:0] d_idx_ff;       // index of registered distance
   logic [DistW-1:0] dist_ff;
   logic [KW-1:0] kk_ff;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [DistW-1:0] bd_ff [KMax];
   logic [IdxW-1:0] bi_ff [KMax];
   logic [SlotW-1:0] oslot_ff, oslot_in;
   logic [IdxW-1:0] match_idx_ff;
   logic match_ff;

   logic signed [16:0] dx, dy, dz;
   logic [33:0] sx, sy, sz;

   always_ff @(posedge clock) begin
      if (ctl.write_pt) begin
         mem_x[count_ff[IdxW-1:0]] <= req_ff.coord_x;
         mem_y[count_ff[IdxW-1:0]] <= req_ff.coord_y;
         mem_z[count_ff[IdxW-1:0]] <= req_ff.coord_z;
      end
      if (ctl.rd_issue) begin
         rd_x_ff <= mem_x[scan_ff[IdxW-1:0]];
         rd_y_ff <= mem_y[scan_ff[IdxW-1:0]];
         rd_z_ff <= mem_z[scan_ff[IdxW-1:0]];
         rd_idx_ff <= scan_ff[IdxW-1:0];
      end
   end

   always_comb begin
      dx = 17'(signed'(rd_x_ff)) - 17'(req_ff.coord_x);
      dy = 17'(signed'(rd_y_ff)) - 17'(req_ff.coord_y);
      dz = 17'(signed'(rd_z_ff)) - 17'(req_ff.coord_z);
      sx = 34'(dx * dx);
      sy = 34'(dy * dy);
      sz = 34'(dz * dz);
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.write_pt) begin
         count_in = count_ff + 1'b1;
      end
      scan_in = scan_ff;
      if (ctl.scan_clr) begin
         scan_in = '0;
      end else if (ctl.rd_issue) begin
         scan_in = scan_ff + 1'b1;
      end
      oslot_in = oslot_ff;
      if (ctl.out_clr) begin
         oslot_in = '0;
      end else if (ctl.emit_edge) begin
         oslot_in = oslot_ff + 1'b1;
      end
   end

   // Sorted insertion: every slot compares with the new distance in parallel.
   logic [KMax-1:0] lt;
   logic [KW-1:0] pos;
   always_comb begin
      for (int s = 0; s < KMax; s++) begin
         lt[s] = (KW'(s) < cnt_ff) && (dist_ff < bd_ff[s]);
      end
      pos = cnt_ff;
      for (int s = KMax - 1; s >= 0; s--) begin
         if (lt[s]) begin
            pos = KW'(s);
         end
      end
      cnt_in = cnt_ff;
      if (ctl.capture) begin
         cnt_in = '0;
      end else if (ctl.ins_en && pos < kk_ff && cnt_ff < kk_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff <= '0;
         cnt_ff <= '0;
         oslot_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         scan_ff <= scan_in;
         cnt_ff <= cnt_in;
         oslot_ff <= oslot_in;
         if (ctl.capture) begin
            match_ff <= 1'b0;
         end else if (ctl.dist_en && !match_ff && (sx + sy + sz) == '0) begin
            match_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_in;
         kk_ff <= kk_in;
      end
      if (ctl.dist_en) begin
         dist_ff <= DistW'(sx) + DistW'(sy) + DistW'(sz);
         d_idx_ff <= rd_idx_ff;
         if (!match_ff && (sx + sy + sz) == '0) begin
            match_idx_ff <= rd_idx_ff;
         end
      end
      if (ctl.ins_en && pos < kk_ff) begin
         for (int s = 0; s < KMax; s++) begin
            if (KW'(s) == pos) begin
               bd_ff[s] <= dist_ff;
               bi_ff[s] <= d_idx_ff;
            end else if (KW'(s) > pos && s > 0) begin
               bd_ff[s] <= bd_ff[(s == 0) ? 0 : s - 1];
               bi_ff[s] <= bi_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   always_comb begin
      sts.cmd = req_ff.cmd;
      sts.full = (count_ff == CntW'(MaxNodes));
      sts.empty = (count_ff == '0);
      sts.scan_done = (scan_ff == count_ff);
      sts.match = match_ff;
      sts.last_edge = (KW'(oslot_ff) + 1'b1 == cnt_ff);
      rsp_data = '0;
      rsp_data.status = ctl.status;
      rsp_data.last = 1'b1;
      unique case (ctl.status)
         ST_LOADED: rsp_data.node_index = 8'(count_ff);
         ST_PRESENT: rsp_data.node_index = 8'(match_idx_ff);
         ST_EDGE: begin
            rsp_data.node_index = 8'(count_ff - 1'b1);
            rsp_data.neighbor_index = 8'(bi_ff[oslot_ff]);
            rsp_data.last = sts.last_edge;
         end
         default: rsp_data.node_index = '0;
      endcase
   end

endmodule

### rtl/knn_ctrl.sv
module knn_ctrl
   import knn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl,
   input  sts_type sts
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECIDE = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_DIST   = 8'b0000_1000,
      S_INS    = 8'b0001_0000,
      S_CHECK  = 8'b0010_0000,
      S_ONE    = 8'b0100_0000,
      S_EDGE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] status_ff, status_in;
   logic matchpass_ff, matchpass_in;   // first scan looks for a duplicate

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      matchpass_in = matchpass_ff;
      ctl = '0;
      ctl.status = status_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.scan_clr = 1'b1;
            ctl.out_clr = 1'b1;
            matchpass_in = 1'b1;
            if (sts.cmd == CMD_LOAD) begin
               status_in = sts.full ? ST_FULL : ST_LOADED;
               state_in = S_ONE;
            end else if (sts.empty) begin
               status_in = ST_EMPTY;
               state_in = S_ONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctl.rd_issue = 1'b1;
            state_in = S_DIST;
         end
         S_DIST: begin
            ctl.dist_en = 1'b1;
            state_in = matchpass_ff ? S_CHECK : S_INS;
         end
         S_INS: begin
            ctl.ins_en = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.scan_done) begin
               state_in = S_READ;
            end else if (matchpass_ff) begin
               if (sts.match) begin
                  status_in = ST_PRESENT;
                  state_in = S_ONE;
               end else if (sts.full) begin
                  status_in = ST_FULL;
                  state_in = S_ONE;
               end else begin
                  matchpass_in = 1'b0;
                  ctl.scan_clr = 1'b1;
                  state_in = S_READ;
               end
            end else begin
               ctl.write_pt = 1'b1;
               status_in = ST_EDGE;
               state_in = S_EDGE;
            end
         end
         S_ONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.write_pt = (status_ff == ST_LOADED);
               state_in = S_IDLE;
            end
         end
         S_EDGE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.emit_edge = 1'b1;
               if (sts.last_edge) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_EDGE;
         matchpass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         matchpass_ff <= matchpass_in;
      end
   end

endmodule
